FILE: hdl/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared constants and types for the linked block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lba_pkg;

  localparam int NumBlocks = 128;
  localparam int NumFiles  = 32;
  localparam int BlkW      = $clog2(NumBlocks);
  localparam int LinkW     = $clog2(NumBlocks + 1);
  localparam int FileW     = $clog2(NumFiles);
  localparam int KeyW      = 64;
  localparam int CntW      = 8;
  localparam int StW       = 3;

  localparam logic [LinkW-1:0] EndLink = LinkW'(NumBlocks);

  typedef enum logic [StW-1:0] {
    StOk       = 3'd0,
    StTooBig   = 3'd1,
    StDup      = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4,
    StZero     = 3'd5
  } status_e;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncDelete = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/linked_block_allocator_top.sv
// ----------------------------------------------------------------------------
// linked_block_allocator_top
// Linked disk block allocator with a file table, one result word per request.
// ----------------------------------------------------------------------------
// Steps: the table lookup scans every file entry; insert then scans the block
//   used bits one block a cycle; delete walks the chain one link per cycle
//   through the link memory (registered read).
// Throughput: one request at a time; no new request is taken until the result
//   word has been accepted.
// Reset: rst_ni clears the used bits (flops) and table valid bits and sets the
//   free count to NumBlocks; no clearing pass is needed.
`default_nettype none

module linked_block_allocator_top import lba_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            func_i,
  input  wire logic [KeyW-1:0] name_key_i,
  input  wire logic [CntW-1:0] block_count_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [StW-1:0]       status_o,
  output logic [BlkW-1:0]      first_block_o,
  output logic [CntW-1:0]      blocks_moved_o,
  output logic [CntW-1:0]      free_count_o
);

  typedef enum logic [2:0] {
    SIdle, SLook, SLookW, SAlloc, SWalk, SWalkW, SDone
  } state_e;

  state_e               state_q;
  logic                 func_q;
  logic [KeyW-1:0]      key_q;
  logic [CntW-1:0]      want_q;
  logic [FileW:0]       fidx_q;      // table scan index, one extra bit for end
  logic                 hit_q, hole_q;
  logic [FileW-1:0]     hit_idx_q, hole_idx_q;
  logic [LinkW-1:0]     bidx_q;      // block scan index / chain cursor
  logic [BlkW-1:0]      prev_q, start_q;
  logic                 have_prev_q;
  logic [CntW-1:0]      got_q;
  logic [CntW-1:0]      free_q;
  logic [NumBlocks-1:0] used_q;
  logic [NumFiles-1:0]  valid_q;

  // Table and link memories: one write and one read per cycle, read registered.
  logic [KeyW-1:0]  key_mem   [NumFiles];
  logic [BlkW-1:0]  start_mem [NumFiles];
  logic [LinkW-1:0] link_mem  [NumBlocks];
  logic [KeyW-1:0]  key_rd_q;
  logic [BlkW-1:0]  start_rd_q;
  logic [LinkW-1:0] link_rd_q;
  logic [FileW-1:0] rd_fidx_q;
  logic             rd_fok_q;

  status_e          st_q;
  logic [BlkW-1:0]  ofirst_q;
  logic [CntW-1:0]  omoved_q;

  logic             tw_en, lw_en;
  logic [FileW-1:0] tw_idx;
  logic [BlkW-1:0]  lw_idx;
  logic [LinkW-1:0] lw_data;
  logic [BlkW-1:0]  lr_idx;
  logic             alloc_take, alloc_done;

  assign in_ready_o     = (state_q == SIdle);
  assign out_valid_o    = (state_q == SDone);
  assign status_o       = st_q;
  assign first_block_o  = ofirst_q;
  assign blocks_moved_o = omoved_q;
  assign free_count_o   = free_q;

  // Link memory write/read selection.
  always_comb begin
    alloc_take = 1'b0;
    alloc_done = 1'b0;
    lw_en      = 1'b0;
    lw_idx     = prev_q;
    lw_data    = EndLink;
    lr_idx     = bidx_q[BlkW-1:0];
    tw_en      = 1'b0;
    tw_idx     = hole_idx_q;
    if (state_q == SAlloc) begin
      alloc_done = (bidx_q == LinkW'(NumBlocks)) || (got_q == want_q);
      alloc_take = !alloc_done && !used_q[bidx_q[BlkW-1:0]];
    end
    // Point the previous block at the one just taken; terminate on completion.
    if (alloc_take && have_prev_q) begin
      lw_en   = 1'b1;
      lw_data = bidx_q;
    end
    if (alloc_done) begin
      lw_en = have_prev_q;
      tw_en = 1'b1;
    end
    // Read the start block's link while the walk starts, then follow links.
    if (state_q == SWalk) lr_idx = start_q;
    if (state_q == SWalkW) lr_idx = link_rd_q[BlkW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) link_mem[lw_idx] <= lw_data;
    if (tw_en) begin
      key_mem[tw_idx]   <= key_q;
      start_mem[tw_idx] <= start_q;
    end
    link_rd_q  <= link_mem[lr_idx];
    key_rd_q   <= key_mem[fidx_q[FileW-1:0]];
    start_rd_q <= start_mem[fidx_q[FileW-1:0]];
    rd_fidx_q  <= fidx_q[FileW-1:0];
    rd_fok_q   <= (state_q == SLook) && (fidx_q < (FileW+1)'(NumFiles));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      used_q  <= '0;
      valid_q <= '0;
      free_q  <= CntW'(NumBlocks);
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) begin
          func_q <= func_i; key_q <= name_key_i; want_q <= block_count_i;
          fidx_q <= '0; hit_q <= 1'b0; hole_q <= 1'b0;
          state_q <= SLook;
        end
        SLook: begin
          // Advance address each cycle; compare the read data in the following cycle.
          if (fidx_q <= (FileW+1)'(NumFiles)) fidx_q <= fidx_q + 1'b1;
          if (rd_fok_q) begin
            if (valid_q[rd_fidx_q] && key_rd_q == key_q && !hit_q) begin
              hit_q <= 1'b1; hit_idx_q <= rd_fidx_q; start_q <= start_rd_q;
            end
            if (!valid_q[rd_fidx_q] && !hole_q) begin
              hole_q <= 1'b1; hole_idx_q <= rd_fidx_q;
            end
          end
          if (fidx_q == (FileW+1)'(NumFiles)) state_q <= SLookW;
        end
        SLookW: begin
          if (rd_fok_q) begin
            if (valid_q[rd_fidx_q] && key_rd_q == key_q && !hit_q) begin
              hit_q <= 1'b1; hit_idx_q <= rd_fidx_q; start_q <= start_rd_q;
            end
          end
          ofirst_q <= '0; omoved_q <= '0; bidx_q <= '0; got_q <= '0;
          have_prev_q <= 1'b0;
          state_q  <= SDone;
          if (func_q == FuncInsert) begin
            if (want_q == '0)                  st_q <= StZero;
            else if (want_q > free_q)          st_q <= StTooBig;
            else if (hit_q || (rd_fok_q && valid_q[rd_fidx_q] && key_rd_q == key_q))
                                               st_q <= StDup;
            else if (!hole_q)                  st_q <= StFull;
            else begin st_q <= StOk; state_q <= SAlloc; end
          end else begin
            if (hit_q || (rd_fok_q && valid_q[rd_fidx_q] && key_rd_q == key_q)) begin
              st_q <= StOk; state_q <= SWalk;
            end else st_q <= StNotFound;
          end
        end
        SAlloc: begin
          if (alloc_done) begin
            valid_q[hole_idx_q] <= 1'b1;
            free_q   <= (free_q >= got_q) ? free_q - got_q : '0;
            ofirst_q <= start_q; omoved_q <= got_q;
            state_q  <= SDone;
          end else begin
            if (alloc_take) begin
              used_q[bidx_q[BlkW-1:0]] <= 1'b1;
              if (!have_prev_q) start_q <= bidx_q[BlkW-1:0];
              prev_q <= bidx_q[BlkW-1:0]; have_prev_q <= 1'b1;
              got_q  <= got_q + 1'b1;
            end
            bidx_q <= bidx_q + 1'b1;
          end
        end
        SWalk: begin
          // Start walk at the entry's first block; read its link.
          valid_q[hit_idx_q] <= 1'b0;
          ofirst_q <= start_q;
          used_q[start_q] <= 1'b0;
          got_q  <= CntW'(1);
          bidx_q <= LinkW'(start_q);
          state_q <= SWalkW;
        end
        SWalkW: begin
          // link_rd_q holds the link of block bidx_q (read issued last cycle).
          if (link_rd_q >= LinkW'(NumBlocks) || got_q >= CntW'(NumBlocks)) begin
            free_q <= (CntW+1)'(free_q) + (CntW+1)'(got_q) > (CntW+1)'(NumBlocks)
                      ? CntW'(NumBlocks) : free_q + got_q;
            omoved_q <= got_q;
            state_q  <= SDone;
          end else begin
            used_q[link_rd_q[BlkW-1:0]] <= 1'b0;
            got_q  <= got_q + 1'b1;
            bidx_q <= link_rd_q;
          end
        end
        SDone: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CntW'(NumBlocks))
    else $error("free count above disk size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SAlloc) |-> got_q <= want_q)
    else $error("allocated past request");

endmodule

`default_nettype wire

FILE: bench/linked_block_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// linked_block_allocator_top_tb
// Self-checking bench: directed table of requests, then random insert/delete
// traffic, every result word compared against a behavioral allocator model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_block_allocator_top_tb;
  import lba_pkg::*;

  // Expected result word
  typedef struct packed {
    logic [StW-1:0]  status;
    logic [BlkW-1:0] first;
    logic [CntW-1:0] moved;
    logic [CntW-1:0] free;
  } alloc_res_t;

  // Directed row: request plus optional typed-in expectation
  typedef struct {
    logic            func;
    logic [KeyW-1:0] key;
    logic [CntW-1:0] count;
    bit              has_exp;
    status_e         st;
    int              first;
    int              moved;
    int              free;
  } alloc_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            func_i = 1'b0;
  logic [KeyW-1:0] name_key_i = '0;
  logic [CntW-1:0] block_count_i = '0;
  logic            out_ready_i = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  logic [StW-1:0]  status_o;
  logic [BlkW-1:0] first_block_o;
  logic [CntW-1:0] blocks_moved_o;
  logic [CntW-1:0] free_count_o;

  linked_block_allocator_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .name_key_i,
    .block_count_i, .out_valid_o, .out_ready_i, .status_o, .first_block_o,
    .blocks_moved_o, .free_count_o
  );

  // Shadow copy of the disk and file table
  bit              disk_used [NumBlocks];
  int              disk_link [NumBlocks];
  bit              file_valid [NumFiles];
  logic [KeyW-1:0] file_key [NumFiles];
  int              file_start [NumFiles];
  int              disk_free;

  alloc_res_t      pending_q[$];
  logic [KeyW-1:0] key_pool[$];   // keys likely live, reused for deletes/dups
  int              mismatches = 0;
  bit              sink_idle_on = 1'b1;
  bit              hold_sink = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one request to the shadow state, return the word it must produce
  function automatic alloc_res_t allocate_or_free(logic fn, logic [KeyW-1:0] key,
                                                  int want);
    alloc_res_t r;
    int hit, slot, prev, got, cur, freed;
    r = '0;
    hit = -1;
    slot = -1;
    for (int i = 0; i < NumFiles; i++) begin
      if (file_valid[i] && file_key[i] == key && hit < 0) hit = i;
      if (!file_valid[i] && slot < 0) slot = i;
    end
    if (fn == FuncInsert) begin
      if (want == 0) r.status = StZero;
      else if (want > disk_free) r.status = StTooBig;
      else if (hit >= 0) r.status = StDup;
      else if (slot < 0) r.status = StFull;
      else begin
        prev = -1;
        got = 0;
        for (int i = 0; i < NumBlocks && got < want; i++) begin
          if (!disk_used[i]) begin
            if (prev < 0) r.first = BlkW'(i);
            else disk_link[prev] = i;
            disk_used[i] = 1'b1;
            disk_link[i] = NumBlocks;
            prev = i;
            got++;
          end
        end
        file_valid[slot] = 1'b1;
        file_key[slot] = key;
        file_start[slot] = r.first;
        disk_free -= got;
        r.status = StOk;
        r.moved = CntW'(got);
      end
    end else if (hit < 0) begin
      r.status = StNotFound;
    end else begin
      cur = file_start[hit];
      freed = 0;
      while (cur < NumBlocks && freed < NumBlocks) begin
        disk_used[cur] = 1'b0;
        freed++;
        cur = disk_link[cur];
      end
      disk_free = (disk_free + freed > NumBlocks) ? NumBlocks : disk_free + freed;
      file_valid[hit] = 1'b0;
      r.status = StOk;
      r.first = BlkW'(file_start[hit]);
      r.moved = CntW'(freed);
    end
    r.free = CntW'(disk_free);
    return r;
  endfunction

  // Drive one request word and hold it until accepted
  task automatic send_word(logic fn, logic [KeyW-1:0] key, logic [CntW-1:0] cnt,
                           bit gaps);
    while (gaps && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    name_key_i <= key;
    block_count_i <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(allocate_or_free(fn, key, int'(cnt)));
  endtask

  // Result side: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word st=%0d", status_o);
        end else begin
          alloc_res_t e;
          e = pending_q.pop_front();
          if ({status_o, first_block_o, blocks_moved_o, free_count_o} !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp st=%0d fb=%0d mv=%0d fr=%0d got %0d %0d %0d %0d",
                       e.status, e.first, e.moved, e.free, status_o,
                       first_block_o, blocks_moved_o, free_count_o);
          end
        end
      end
      out_ready_i <= !hold_sink && !(sink_idle_on && $urandom_range(99) < 14);
    end
  end

  alloc_row_t rows[$];

  function automatic alloc_row_t mk(logic fn, logic [KeyW-1:0] key, int cnt,
                                    bit he, status_e st, int fb, int mv, int fr);
    alloc_row_t r;
    r.func = fn; r.key = key; r.count = CntW'(cnt); r.has_exp = he;
    r.st = st; r.first = fb; r.moved = mv; r.free = fr;
    return r;
  endfunction

  initial begin
    alloc_res_t want;
    logic [KeyW-1:0] k;
    int n, cnt, wait_cycles;
    for (int i = 0; i < NumBlocks; i++) begin
      disk_used[i] = 1'b0;
      disk_link[i] = NumBlocks;
    end
    for (int i = 0; i < NumFiles; i++) file_valid[i] = 1'b0;
    disk_free = NumBlocks;

    // Directed rows: zero size, delete unknown, extremes, duplicate, too big
    rows.push_back(mk(FuncInsert, 64'h1, 0, 1, StZero, 0, 0, 128));
    rows.push_back(mk(FuncDelete, '1, 0, 1, StNotFound, 0, 0, 128));
    rows.push_back(mk(FuncInsert, 64'h0, 255, 1, StTooBig, 0, 0, 128));
    rows.push_back(mk(FuncInsert, 64'h0, 128, 1, StOk, 0, 128, 0));
    rows.push_back(mk(FuncInsert, '1, 1, 1, StTooBig, 0, 0, 0));
    rows.push_back(mk(FuncDelete, 64'h0, 200, 1, StOk, 0, 128, 128));
    rows.push_back(mk(FuncInsert, '1, 3, 1, StOk, 0, 3, 125));
    rows.push_back(mk(FuncInsert, '1, 2, 1, StDup, 0, 0, 125));
    rows.push_back(mk(FuncInsert, 64'hAAAA_5555_AAAA_5555, 5, 1, StOk, 3, 5, 120));
    rows.push_back(mk(FuncDelete, '1, 0, 1, StOk, 0, 3, 123));
    rows.push_back(mk(FuncInsert, 64'h5555_AAAA_5555_AAAA, 7, 0, StOk, 0, 0, 0));
    rows.push_back(mk(FuncDelete, 64'hAAAA_5555_AAAA_5555, 0, 0, StOk, 0, 0, 0));
    // Fill the table with one-block files, then hit the full-table refusal
    for (int i = 0; i < NumFiles; i++)
      rows.push_back(mk(FuncInsert, 64'h100 + i, 1, 0, StOk, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_word(rows[i].func, rows[i].key, rows[i].count, 1'b1);
      if (rows[i].has_exp) begin
        want = '{rows[i].st, BlkW'(rows[i].first), CntW'(rows[i].moved),
                 CntW'(rows[i].free)};
        if (pending_q[$] !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("model disagrees with table row %0d", i);
        end
      end
    end
    // Table is full now (31 new + the one live file)
    send_word(FuncInsert, 64'hFFFF, 1, 1'b1);
    for (int i = 0; i < NumFiles; i++) send_word(FuncDelete, 64'h100 + i, 0, 1'b1);

    // Sender pauses until everything has drained
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);

    // Receiver holds off a long stretch while requests keep coming
    hold_sink = 1'b1;
    fork
      begin
        wait_cycles = 0;
        while (wait_cycles < 2000) begin
          @(posedge clk_i);
          wait_cycles++;
        end
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_word(FuncInsert, 64'h200 + i, 2, 1'b0);
    join

    // Random traffic; a quiet stretch with no idling on either side
    for (int it = 0; it < 370; it++) begin
      sink_idle_on = !(it >= 150 && it < 230);
      if (key_pool.size() != 0 && $urandom_range(99) < 40) begin
        n = $urandom_range(key_pool.size() - 1);
        k = key_pool[n];
        if ($urandom_range(3) != 0) begin
          key_pool.delete(n);
          send_word(FuncDelete, k, CntW'($urandom), it < 150 || it >= 230);
          continue;
        end
      end else begin
        k = {$urandom, $urandom};
        if ($urandom_range(3) == 0) k = KeyW'($urandom_range(15));
        key_pool.push_back(k);
      end
      case ($urandom_range(9))
        0: cnt = $urandom_range(255);
        1: cnt = 0;
        2: cnt = $urandom_range(128, 64);
        default: cnt = $urandom_range(12, 1);
      endcase
      if ($urandom_range(19) == 0)
        send_word(FuncDelete, k, CntW'(cnt), it < 150 || it >= 230);
      else send_word(FuncInsert, k, CntW'(cnt), it < 150 || it >= 230);
    end
    sink_idle_on = 1'b1;
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
